/* hw/rtl/hotp_code_generator_top_assert.svh */
// Assertion macros for the HOTP code generator top level.
// Used by hotp_code_generator_top.sv only.
`ifndef HOTP_CODE_GENERATOR_TOP_ASSERT_SVH
`define HOTP_CODE_GENERATOR_TOP_ASSERT_SVH
// implication checked on every edge outside reset
`define HOTP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define HOTP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* hw/rtl/hotp_pkg.sv */
// Shared types and constants for the HOTP code generator.
// No dependencies.
package hotp_pkg;
	localparam int MAX_KEY_BYTES = 32;
	localparam logic [2:0] CFG_KEY3   = 3'd3;
	localparam logic [2:0] CFG_KLEN   = 3'd4;
	localparam logic [2:0] CFG_DIGITS = 3'd5;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;
	localparam logic [159:0] SHA_IV = {H0, H1, H2, H3, H4};

	// block-builder to SHA core control
	typedef struct packed {
		logic start;
		logic load_iv;
	} sha_ctl_t;

	function automatic logic [31:0] pow_ten(input logic [3:0] n);
		logic [31:0] r;
		case (n)
			4'd0: r = 32'd1;
			4'd1: r = 32'd10;
			4'd2: r = 32'd100;
			4'd3: r = 32'd1000;
			4'd4: r = 32'd10000;
			4'd5: r = 32'd100000;
			4'd6: r = 32'd1000000;
			4'd7: r = 32'd10000000;
			4'd8: r = 32'd100000000;
			4'd9: r = 32'd1000000000;
			default: r = 32'd0;
		endcase
		return r;
	endfunction
endpackage

/* hw/rtl/hotp_sha1_core.sv */
// Iterative SHA-1 compression: one round per cycle, 80 rounds per block.
// Uses hotp_pkg.
module hotp_sha1_core import hotp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  sha_ctl_t     ctl,
	input  logic [511:0] block,
	output logic         done,
	output logic [159:0] digest
);
	logic [511:0] w_q;
	logic [159:0] h_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [6:0]   rnd_q;
	logic         busy_q;
	logic [31:0]  f, k, t, wn, w0;
	logic [159:0] hbase;

	assign w0 = w_q[511:480];
	assign wn = {w_q[447:416] ^ w_q[255:224] ^ w_q[95:64] ^ w_q[511:480]} << 1
		| {31'd0, w_q[447] ^ w_q[255] ^ w_q[95] ^ w_q[511]};

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = 32'h5A827999;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = 32'h6ED9EBA1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = 32'hCA62C1D6;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w0;
	end

	assign hbase = ctl.load_iv ? SHA_IV : h_q;
	assign digest = h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				if (rnd_q == 7'd79) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				rnd_q <= rnd_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			w_q <= block;
			h_q <= hbase;
			{a_q, b_q, c_q, d_q, e_q} <= hbase;
		end else if (busy_q) begin
			w_q <= {w_q[479:0], wn};
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t;
			if (rnd_q == 7'd79)
				h_q <= {h_q[159:128] + t, h_q[127:96] + a_q,
					h_q[95:64] + {b_q[1:0], b_q[31:2]}, h_q[63:32] + c_q,
					h_q[31:0] + d_q};
		end
	end
endmodule

/* hw/rtl/hotp_mod_unit.sv */
// Restoring remainder unit: 31-bit value modulo a 32-bit divisor, one bit a cycle.
// No package dependencies.
module hotp_mod_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] value,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [30:0] rem
);
	logic [31:0] r_q;
	logic [30:0] v_q;
	logic [31:0] d_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [32:0] sh, diff;

	assign sh   = {r_q, v_q[30]};
	assign diff = sh - {1'b0, d_q};
	assign rem  = r_q[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd30) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			v_q <= value;
			d_q <= divisor;
		end else if (busy_q) begin
			v_q <= {v_q[29:0], 1'b0};
			r_q <= diff[32] ? sh[31:0] : diff[31:0];
		end
	end
endmodule

/* hw/rtl/hotp_code_generator_top.sv */
// HOTP code generator: HMAC-SHA1 of a 64-bit counter, dynamic truncation, decimal modulo below ten digits.
// Steps: four SHA-1 blocks (ipad, counter, opad, inner digest), a truncation step, a remainder step.
// in_ready is low while an item is in work; a new counter is taken only once the sequencer is idle.
// A finished code waits in an output register; the next counter may be taken meanwhile.
// Reset (arst_n, async low): key words 0, key_length 20, digit_count 6, sequencer idle.
// Depends on hotp_pkg, hotp_sha1_core, hotp_mod_unit and the assertion header.
`include "hotp_code_generator_top_assert.svh"
module hotp_code_generator_top import hotp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] counter,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] otp_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	// sequencer phases
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_IPAD  = 3'd1;
	localparam logic [2:0] ST_IMSG  = 3'd2;
	localparam logic [2:0] ST_OPAD  = 3'd3;
	localparam logic [2:0] ST_OMSG  = 3'd4;
	localparam logic [2:0] ST_TRUNC = 3'd5;
	localparam logic [2:0] ST_MOD   = 3'd6;

	logic [63:0]  key_q [4];
	logic [5:0]   klen_q;
	logic [3:0]   digits_q;
	logic [2:0]   st_q;
	logic         launch_q;   // start pulse for the next SHA block
	logic [63:0]  ctr_q;
	logic [159:0] inner_q;
	logic [30:0]  trunc_q;
	logic         out_valid_q;
	logic [30:0]  code_q;

	sha_ctl_t     ctl;
	logic [511:0] blk;
	logic [255:0] key_pad;
	logic         sha_done;
	logic [159:0] digest;
	logic         mod_start, mod_done;
	logic [30:0]  mod_rem;
	logic [5:0]   klen_eff;
	logic [31:0]  tr_word;

	assign cfg_ready = 1'b1;
	assign in_ready  = (st_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign otp_code  = code_q;
	assign klen_eff  = (klen_q > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES) : klen_q;

	// key bytes beyond the length read as zero
	always_comb begin
		for (int i = 0; i < 32; i++)
			key_pad[255 - 8*i -: 8] = (6'(i) < klen_eff) ?
				key_q[i/8][63 - 8*(i%8) -: 8] : 8'h00;
	end

	// block for the current phase
	always_comb begin
		case (st_q)
			ST_IPAD: blk = {key_pad ^ {32{8'h36}}, {32{8'h36}}};
			ST_IMSG: blk = {ctr_q, 8'h80, 376'd0, 64'd576};
			ST_OPAD: blk = {key_pad ^ {32{8'h5C}}, {32{8'h5C}}};
			ST_OMSG: blk = {inner_q, 8'h80, 280'd0, 64'd672};
			default: blk = '0;
		endcase
	end

	assign ctl.start   = launch_q;
	assign ctl.load_iv = (st_q == ST_IPAD) || (st_q == ST_OPAD);

	hotp_sha1_core u_sha (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .block(blk),
		.done(sha_done), .digest(digest)
	);

	// dynamic truncation off the low nibble of the last digest byte
	always_comb begin
		tr_word = '0;
		for (int o = 0; o < 16; o++)
			if (digest[3:0] == 4'(o))
				tr_word = digest[159 - 8*o -: 32];
	end

	// restarted every cycle spent waiting in ST_TRUNC; the last start counts
	assign mod_start = (st_q == ST_TRUNC);

	hotp_mod_unit u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .value(trunc_q),
		.divisor(pow_ten(digits_q)), .done(mod_done), .rem(mod_rem)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				key_q[i] <= '0;
			klen_q   <= 6'd20;
			digits_q <= 4'd6;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index <= CFG_KEY3)
				key_q[cfg_index[1:0]] <= cfg_data;
			else if (cfg_index == CFG_KLEN)
				klen_q <= cfg_data[5:0];
			else if (cfg_index == CFG_DIGITS)
				digits_q <= cfg_data[3:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			launch_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (in_valid) begin
					st_q     <= ST_IPAD;
					launch_q <= 1'b1;
				end
				ST_IPAD: if (sha_done) begin
					st_q     <= ST_IMSG;
					launch_q <= 1'b1;
				end
				ST_IMSG: if (sha_done) begin
					st_q     <= ST_OPAD;
					launch_q <= 1'b1;
				end
				ST_OPAD: if (sha_done) begin
					st_q     <= ST_OMSG;
					launch_q <= 1'b1;
				end
				ST_OMSG: if (sha_done)
					st_q <= ST_TRUNC;
				// hold the remainder step until the previous code has been taken
				ST_TRUNC: if (!out_valid_q || out_ready) begin
					st_q <= ST_MOD;
				end
				ST_MOD: if (mod_done) begin
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
			if (st_q == ST_MOD && mod_done)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_valid)
			ctr_q <= counter;
		if (st_q == ST_IMSG && sha_done)
			inner_q <= digest;
		if (st_q == ST_OMSG && sha_done)
			trunc_q <= tr_word[30:0];
		if (st_q == ST_MOD && mod_done)
			code_q <= (digits_q < 4'd10) ? mod_rem : trunc_q;
	end

	`HOTP_ASSERT_IMPL(a_busy_not_ready, st_q != ST_IDLE, !in_ready, "ready while busy")
	`HOTP_ASSERT_NEXT(a_take_starts, in_valid && in_ready, st_q == ST_IPAD && launch_q,
		"accepted item did not launch hash")
	`HOTP_ASSERT_IMPL(a_done_phase, sha_done, st_q == ST_IPAD || st_q == ST_IMSG ||
		st_q == ST_OPAD || st_q == ST_OMSG, "hash done outside hash phase")
endmodule

/* test/hotp_code_generator_top_tb.sv */
// Testbench for hotp_code_generator_top: HMAC-SHA1 one-time codes checked against an in-bench model.
// Needs hotp_pkg and the HOTP RTL only; a directed table is followed by randomized key/digit phases.
`timescale 1ns / 100ps
module hotp_code_generator_top_tb;
	import hotp_pkg::*;

	// register indexes not named by the package
	localparam logic [2:0] CFG_KEY0 = 3'd0;
	localparam logic [2:0] CFG_KEY1 = 3'd1;
	localparam logic [2:0] CFG_KEY2 = 3'd2;
	localparam logic [2:0] CFG_UNUSED6 = 3'd6;
	localparam logic [2:0] CFG_UNUSED7 = 3'd7;

	localparam int LATENCY = 400;		// idle wait after the last code, longer than one code takes
	localparam int STALL_LIMIT = 20000;	// cycles with no transfer on any channel
	localparam int PHASES = 15;
	localparam int PHASE_ITEMS = 100;

	typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_ITEM_CHK} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [2:0]  index;	// register rows
		logic [63:0] data;	// register data or counter
		logic [30:0] code;	// typed-in expected code for ROW_ITEM_CHK
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] counter = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [30:0] otp_code;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	// model copy of the registers
	logic [63:0] key_w [4];
	logic [5:0]  key_len;
	logic [3:0]  digits;

	logic [30:0] expected_codes [$];
	int errors = 0;
	int stall_cycles = 0;
	bit quiet = 0;	// no idling on either side while set

	hotp_code_generator_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .counter(counter),
		.out_valid(out_valid), .out_ready(out_ready), .otp_code(otp_code),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------- model ----------------

	function automatic logic [159:0] sha1_compress(input logic [159:0] h, input logic [511:0] blk);
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = blk[511 - 32 * i -: 32];
		for (int i = 16; i < 80; i++) begin
			t = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
			w[i] = {t[30:0], t[31]};
		end
		{a, b, c, d, e} = h;
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = 32'h5A827999;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d;
				k = 32'hCA62C1D6;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[i];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
	endfunction

	// SHA-1 of (key ^ pad block) followed by one already padded message block
	function automatic logic [159:0] hmac_pass(input logic [7:0] pad, input logic [511:0] msg_blk);
		logic [511:0] kblk;
		int len;
		len = (key_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : key_len;
		for (int i = 0; i < 64; i++)
			kblk[511 - 8 * i -: 8] = ((i < len) ? key_w[i >> 3][63 - 8 * (i & 7) -: 8] : 8'h00) ^ pad;
		return sha1_compress(sha1_compress(SHA_IV, kblk), msg_blk);
	endfunction

	function automatic logic [30:0] hotp_expect(input logic [63:0] cnt);
		logic [159:0] inner, mac;
		logic [3:0] off;
		logic [31:0] p, modulus;
		inner = hmac_pass(8'h36, {cnt, 8'h80, 376'd0, 64'd576});
		mac = hmac_pass(8'h5C, {inner, 8'h80, 280'd0, 64'd672});
		off = mac[3:0];
		p = mac[159 - 8 * off -: 32] & 32'h7FFFFFFF;
		if (digits < 10) begin
			modulus = 1;
			for (int i = 0; i < digits; i++)
				modulus = modulus * 10;
			p = p % modulus;
		end
		return p[30:0];
	endfunction

	// ---------------- drivers ----------------

	task automatic idle_gap();
		while (!quiet && $urandom_range(0, 99) < 10)
			@(negedge clk);
	endtask

	task automatic wait_drained();
		while (expected_codes.size() != 0)
			@(posedge clk);
	endtask

	// registers change only with nothing in work
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		wait_drained();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: key_w[idx] = val;
			CFG_KLEN: key_len = val[5:0];
			CFG_DIGITS: digits = val[3:0];
			default: ;	// unknown index: dropped by the block
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// expected code is queued at the transfer edge, under the settings then in force
	task automatic send_counter(input logic [63:0] cnt);
		@(negedge clk);
		idle_gap();
		in_valid = 1'b1;
		counter = cnt;
		do @(posedge clk); while (!in_ready);
		expected_codes.push_back(hotp_expect(cnt));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	always @(negedge clk)
		out_ready = quiet || ($urandom_range(0, 99) >= 10);

	// ---------------- checking ----------------

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_codes.size() == 0) begin
				$display("%t unexpected code: expected none, actual %0d", $time, otp_code);
				errors++;
			end else begin
				if (otp_code !== expected_codes[0]) begin
					$display("%t otp_code mismatch: expected %0d, actual %0d",
						$time, expected_codes[0], otp_code);
					errors++;
				end
				void'(expected_codes.pop_front());
			end
		end
	end

	// watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------- stimulus ----------------

	// key "12345678901234567890": the published HOTP vectors for counts 0..5 and 9
	stim_row_t directed [] = '{
		'{ROW_CFG, CFG_KEY0, 64'h3132333435363738, 31'd0},
		'{ROW_CFG, CFG_KEY1, 64'h3930313233343536, 31'd0},
		'{ROW_CFG, CFG_KEY2, 64'h3738393000000000, 31'd0},
		'{ROW_ITEM_CHK, 3'd0, 64'd0, 31'd755224},
		'{ROW_ITEM_CHK, 3'd0, 64'd1, 31'd287082},
		'{ROW_ITEM_CHK, 3'd0, 64'd2, 31'd359152},
		'{ROW_ITEM_CHK, 3'd0, 64'd3, 31'd969429},
		'{ROW_ITEM_CHK, 3'd0, 64'd4, 31'd338314},
		'{ROW_ITEM_CHK, 3'd0, 64'd5, 31'd254676},
		'{ROW_ITEM_CHK, 3'd0, 64'd9, 31'd520489},
		'{ROW_ITEM, 3'd0, 64'hFFFFFFFFFFFFFFFF, 31'd0},
		// zero digits: modulo one
		'{ROW_CFG, CFG_DIGITS, 64'd0, 31'd0},
		'{ROW_ITEM_CHK, 3'd0, 64'd5, 31'd0},
		// ten or more digits: full 31-bit truncated value
		'{ROW_CFG, CFG_DIGITS, 64'd10, 31'd0},
		'{ROW_ITEM_CHK, 3'd0, 64'd0, 31'h4C93CF18},
		'{ROW_CFG, CFG_DIGITS, 64'hFFFFFFFFFFFFFFFF, 31'd0},
		'{ROW_ITEM_CHK, 3'd0, 64'd1, 31'h41397EEA},
		// unknown index must leave digits alone
		'{ROW_CFG, CFG_UNUSED7, 64'd3, 31'd0},
		'{ROW_ITEM_CHK, 3'd0, 64'd0, 31'h4C93CF18},
		// empty key, then length past the maximum with key bytes 24..31 set
		'{ROW_CFG, CFG_KLEN, 64'd0, 31'd0},
		'{ROW_ITEM, 3'd0, 64'd7, 31'd0},
		'{ROW_CFG, CFG_KEY3, 64'hFFFFFFFFFFFFFFFF, 31'd0},
		'{ROW_CFG, CFG_KLEN, 64'd63, 31'd0},
		'{ROW_ITEM, 3'd0, 64'h8000000000000001, 31'd0},
		'{ROW_CFG, CFG_DIGITS, 64'd1, 31'd0},
		'{ROW_ITEM, 3'd0, 64'h0123456789ABCDEF, 31'd0}
	};

	initial begin
		logic [63:0] cnt;
		logic [63:0] klen_pick;
		key_w = '{default: 64'd0};
		key_len = 6'd20;
		digits = 4'd6;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table; typed-in codes replace the model's prediction in the queue
		foreach (directed[r]) begin
			case (directed[r].kind)
				ROW_CFG: write_reg(directed[r].index, directed[r].data);
				ROW_ITEM: send_counter(directed[r].data);
				ROW_ITEM_CHK: begin
					send_counter(directed[r].data);
					expected_codes[$] = directed[r].code;
				end
				default: ;
			endcase
		end

		// random phases: fresh key, length and digit count each time
		for (int ph = 0; ph < PHASES; ph++) begin
			quiet = (ph == 4);
			write_reg(CFG_KEY0, {$urandom, $urandom});
			write_reg(CFG_KEY1, {$urandom, $urandom});
			write_reg(CFG_KEY2, {$urandom, $urandom});
			write_reg(CFG_KEY3, {$urandom, $urandom});
			case ($urandom_range(0, 7))
				0: klen_pick = 64'd0;
				1: klen_pick = 64'd1;
				2: klen_pick = 64'd32;
				3: klen_pick = 64'd63;
				4: klen_pick = 64'd20;
				default: klen_pick = {$urandom, $urandom};
			endcase
			write_reg(CFG_KLEN, klen_pick);
			write_reg(CFG_DIGITS, (ph == 0) ? 64'd10 : (ph == 1) ? 64'd1 : {$urandom, $urandom});
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? CFG_UNUSED6 : CFG_UNUSED7, {$urandom, $urandom});
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(0, 19))
					0: cnt = 64'd0;
					1: cnt = 64'hFFFFFFFFFFFFFFFF;
					2: cnt = {32'd0, $urandom};
					default: cnt = {$urandom, $urandom};
				endcase
				// hold the sender until the pipe is empty now and then
				if (ph == 7 && n % 10 == 0)
					wait_drained();
				send_counter(cnt);
			end
		end
		quiet = 0;

		wait_drained();
		repeat (LATENCY) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/hotp_pkg.sv
hw/rtl/hotp_sha1_core.sv
hw/rtl/hotp_mod_unit.sv
hw/rtl/hotp_code_generator_top.sv
test/hotp_code_generator_top_tb.sv
